[hw/rtl/slsm_pkg.sv]
// Shared types and constants for the sorted list set merge block.
// Used by the controller, the datapath and the top level; no dependencies.
package slsm_pkg;

   localparam int LIST_CAPACITY = 16;
   localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
   localparam int IDX_W = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      FUNC_LOAD_FIRST  = 2'd0,
      FUNC_LOAD_SECOND = 2'd1,
      FUNC_RUN         = 2'd2,
      FUNC_NONE        = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OP_MERGE = 2'd0,
      OP_UNION = 2'd1,
      OP_INTER = 2'd2,
      OP_DIFF  = 2'd3
   } set_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic load_first;
      logic load_second;
      logic start;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/slsm_ctrl.sv]
// Controller state machine of the sorted list set merge block.
// Depends on slsm_pkg; drives the datapath through cmd_type commands.
module slsm_ctrl
   import slsm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_func,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   func_type  func;

   assign func = func_type'(req_func);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (func)
                  FUNC_LOAD_FIRST:  cmd.load_first  = 1'b1;
                  FUNC_LOAD_SECOND: cmd.load_second = 1'b1;
                  FUNC_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (status.out_free) begin
               if (status.active) begin
                  cmd.step = 1'b1;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[hw/rtl/slsm_dp.sv]
// Datapath of the sorted list set merge block: list storage, walk pointers,
// one-entry lookahead and the result register. Depends on slsm_pkg.
module slsm_dp
   import slsm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     csr_we,
   input  logic [1:0]               csr_wdata,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value_res,
   output logic                     rsp_last,
   output logic                     rsp_empty_res,
   output logic                     rsp_dropped
);

   logic signed [DATA_W-1:0] first_mem [LIST_CAPACITY];
   logic signed [DATA_W-1:0] second_mem [LIST_CAPACITY];

   set_op_type               set_op_ff;
   logic [CNT_W-1:0]         first_count_ff;
   logic [CNT_W-1:0]         second_count_ff;
   logic                     drop_ff;
   logic [CNT_W-1:0]         i_ff;
   logic [CNT_W-1:0]         j_ff;
   logic signed [DATA_W-1:0] head_a_ff;
   logic signed [DATA_W-1:0] head_b_ff;
   logic                     pend_valid_ff;
   logic signed [DATA_W-1:0] pend_value_ff;
   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   logic                     out_last_ff;
   logic                     out_empty_ff;
   logic                     out_dropped_ff;

   logic signed [DATA_W-1:0] head_a;
   logic signed [DATA_W-1:0] head_b;
   logic                     a_avail;
   logic                     b_avail;
   logic                     emit;
   logic                     adv_i;
   logic                     adv_j;
   logic                     active;
   logic signed [DATA_W-1:0] emit_value;
   logic                     keeps_second;

   assign head_a  = head_a_ff;
   assign head_b  = head_b_ff;
   assign a_avail = i_ff < first_count_ff;
   assign b_avail = j_ff < second_count_ff;
   assign keeps_second = (set_op_ff == OP_MERGE) || (set_op_ff == OP_UNION);

   always_comb begin
      emit       = 1'b0;
      adv_i      = 1'b0;
      adv_j      = 1'b0;
      active     = 1'b1;
      emit_value = head_a;
      if (a_avail && b_avail) begin
         if (head_a < head_b) begin
            emit  = set_op_ff != OP_INTER;
            adv_i = 1'b1;
         end else if (head_b < head_a) begin
            emit       = keeps_second;
            emit_value = head_b;
            adv_j      = 1'b1;
         end else if (set_op_ff == OP_MERGE) begin
            emit       = 1'b1;
            emit_value = head_b;
            adv_j      = 1'b1;
         end else begin
            emit  = set_op_ff != OP_DIFF;
            adv_i = 1'b1;
            adv_j = 1'b1;
         end
      end else if (a_avail && set_op_ff != OP_INTER) begin
         emit  = 1'b1;
         adv_i = 1'b1;
      end else if (b_avail && keeps_second) begin
         emit       = 1'b1;
         emit_value = head_b;
         adv_j      = 1'b1;
      end else begin
         active = 1'b0;
      end
   end

   assign status.active   = active;
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load_first && first_count_ff < CNT_W'(LIST_CAPACITY)) begin
         first_mem[first_count_ff[IDX_W-1:0]] <= req_value;
      end
      if (cmd.load_second && second_count_ff < CNT_W'(LIST_CAPACITY)) begin
         second_mem[second_count_ff[IDX_W-1:0]] <= req_value;
      end
      if (cmd.start) begin
         head_a_ff <= first_mem[IDX_W'(0)];
         head_b_ff <= second_mem[IDX_W'(0)];
      end
      if (cmd.step && adv_i) begin
         head_a_ff <= first_mem[IDX_W'(i_ff + CNT_W'(1))];
      end
      if (cmd.step && adv_j) begin
         head_b_ff <= second_mem[IDX_W'(j_ff + CNT_W'(1))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_op_ff       <= OP_MERGE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         drop_ff         <= 1'b0;
         i_ff            <= '0;
         j_ff            <= '0;
         pend_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            set_op_ff <= set_op_type'(csr_wdata);
         end
         if (cmd.load_first) begin
            if (first_count_ff < CNT_W'(LIST_CAPACITY)) begin
               first_count_ff <= first_count_ff + CNT_W'(1);
            end else begin
               drop_ff <= 1'b1;
            end
         end
         if (cmd.load_second) begin
            if (second_count_ff < CNT_W'(LIST_CAPACITY)) begin
               second_count_ff <= second_count_ff + CNT_W'(1);
            end else begin
               drop_ff <= 1'b1;
            end
         end
         if (cmd.start) begin
            i_ff          <= '0;
            j_ff          <= '0;
            pend_valid_ff <= 1'b0;
         end
         if (rsp_valid && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.step) begin
            if (adv_i) begin
               i_ff <= i_ff + CNT_W'(1);
            end
            if (adv_j) begin
               j_ff <= j_ff + CNT_W'(1);
            end
            if (emit) begin
               pend_valid_ff <= 1'b1;
               if (pend_valid_ff) begin
                  out_valid_ff <= 1'b1;
               end
            end
         end
         if (cmd.finish) begin
            out_valid_ff    <= 1'b1;
            pend_valid_ff   <= 1'b0;
            first_count_ff  <= '0;
            second_count_ff <= '0;
            drop_ff         <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && emit) begin
         pend_value_ff <= emit_value;
         if (pend_valid_ff) begin
            out_value_ff   <= pend_value_ff;
            out_last_ff    <= 1'b0;
            out_empty_ff   <= 1'b0;
            out_dropped_ff <= drop_ff;
         end
      end
      if (cmd.finish) begin
         out_value_ff   <= pend_valid_ff ? pend_value_ff : '0;
         out_last_ff    <= 1'b1;
         out_empty_ff   <= !pend_valid_ff;
         out_dropped_ff <= drop_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value_res = out_value_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_empty_res = out_empty_ff;
   assign rsp_dropped   = out_dropped_ff;

endmodule

[hw/rtl/sorted_list_set_merge.sv]
// Top level of the sorted list set merge block.
// Depends on slsm_pkg, slsm_ctrl and slsm_dp.
//
// Append transfers (func 0 to the first list, func 1 to the second) store one
// value each; an append to a full list is dropped and flagged in the next
// run's results. A run transfer (func 2) starts a two-pointer walk that makes
// one comparison step per cycle while the result port does not stall; no new
// transfer is taken until the walk ends. Results leave through a one-entry
// lookahead and an output register, so the final item carries last; an empty
// result gives one item with empty_res set. Each run clears both lists and the
// drop flag. set_op must be written only while the block is idle; the block
// itself does not enforce this.
module sorted_list_set_merge
   import slsm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_func,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value_res,
   output logic                     rsp_last,
   output logic                     rsp_empty_res,
   output logic                     rsp_dropped,
   input  logic                     csr_we,
   input  logic [1:0]               csr_wdata
);

   cmd_type    cmd;
   status_type status;

   slsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   slsm_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res),
      .rsp_dropped   (rsp_dropped)
   );

endmodule
